// File: rtl/indexed_min_priority_queue_macros.svh
// assertion macros for the indexed min priority queue
`ifndef INDEXED_MIN_PRIORITY_QUEUE_MACROS_SVH
`define INDEXED_MIN_PRIORITY_QUEUE_MACROS_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define IMPQ_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk_i, off during reset
`define IMPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/impq_pkg.sv
// types and constants of the indexed min priority queue
package impq_pkg;

  localparam int unsigned Capacity = 256;
  localparam int unsigned IdxBits  = 8;
  localparam int unsigned KeyBits  = 32;
  localparam int unsigned SlotBits = 9;

  typedef enum logic [2:0] {
    ACT_INSERT   = 3'd0,
    ACT_CHANGE   = 3'd1,
    ACT_DECREASE = 3'd2,
    ACT_INCREASE = 3'd3,
    ACT_DELETE   = 3'd4,
    ACT_DELMIN   = 3'd5,
    ACT_LOOKUP   = 3'd6,
    ACT_CLEAR    = 3'd7
  } action_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_ABSENT    = 3'd1,
    ST_PRESENT   = 3'd2,
    ST_CAPACITY  = 3'd3,
    ST_DIRECTION = 3'd4
  } status_e;

  typedef struct packed {
    action_e              action;
    logic [IdxBits-1:0]   entry_index;
    logic [KeyBits-1:0]   entry_key;
  } in_item_t;

  typedef struct packed {
    status_e              status;
    logic [IdxBits-1:0]   result_index;
    logic [KeyBits-1:0]   result_key;
    logic                 is_present;
    logic [SlotBits-1:0]  entry_count;
    logic                 is_empty;
    logic [IdxBits-1:0]   least_index;
    logic [KeyBits-1:0]   least_key;
  } out_item_t;

  typedef struct packed {
    logic [IdxBits-1:0]   idx;
    logic [KeyBits-1:0]   key;
  } heap_entry_t;

endpackage

// File: rtl/impq_heap_mem.sv
// heap slot memory: one write port, two registered read ports
module impq_heap_mem import impq_pkg::*; (
  input  logic               clk_i,
  input  logic               we_i,
  input  logic [IdxBits-1:0] waddr_i,
  input  heap_entry_t        wdata_i,
  input  logic [IdxBits-1:0] raddr_a_i,
  input  logic [IdxBits-1:0] raddr_b_i,
  output heap_entry_t        rdata_a_o,
  output heap_entry_t        rdata_b_o
);

  heap_entry_t mem_q [Capacity];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

// File: rtl/indexed_min_priority_queue.sv
// indexed binary min-heap priority queue, top level
// sequence: lookup, clear and failed checks pass S_LOOK, S_KEY, S_FIN and S_OUT after accept; a
//   sift, as in an insert, key change or delete, adds a read and an evaluate state per heap level walked
// flow: one item at a time, the next taken only once the result is in the output register
// reset: count and presence bits clear at once, no clearing pass; heap and position
//   memories hold no reset and their contents are only used for held indices
module indexed_min_priority_queue import impq_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  `include "indexed_min_priority_queue_macros.svh"

  // sequencer states
  typedef enum logic [11:0] {
    S_IDLE    = 12'b0000_0000_0001,
    S_LOOK    = 12'b0000_0000_0010,
    S_KEY     = 12'b0000_0000_0100,
    S_LAST_RD = 12'b0000_0000_1000,
    S_LAST    = 12'b0000_0001_0000,
    S_SW_RD   = 12'b0000_0010_0000,
    S_SW_EV   = 12'b0000_0100_0000,
    S_SK_RD   = 12'b0000_1000_0000,
    S_SK_EV   = 12'b0001_0000_0000,
    S_PUT     = 12'b0010_0000_0000,
    S_FIN     = 12'b0100_0000_0000,
    S_OUT     = 12'b1000_0000_0000
  } state_e;

  // heap slot (1 based, 10 bits for the child arithmetic) to memory address
  function automatic logic [IdxBits-1:0] slot_addr(input logic [SlotBits:0] slot);
    logic [SlotBits:0] a;
    a = slot - (SlotBits+1)'(1);
    return a[IdxBits-1:0];
  endfunction

  state_e              state_q, state_d;
  action_e             act_q, act_d;
  logic [IdxBits-1:0]  idx_q, idx_d;
  logic [KeyBits-1:0]  key_q, key_d;
  logic                held_q, held_d;
  logic [SlotBits-1:0] p_q, p_d;          // current hole in the heap
  logic [SlotBits-1:0] count_q, count_d;
  heap_entry_t         item_q, item_d;    // entry carried by the sift
  logic                swim_q, swim_d;
  logic                sink_q, sink_d;
  status_e             status_q, status_d;
  logic [IdxBits-1:0]  res_idx_q, res_idx_d;
  logic [KeyBits-1:0]  res_key_q, res_key_d;
  logic                removed_q, removed_d;
  logic [Capacity-1:0] valid_q, valid_d;  // index held, cleared at once by reset
  logic                out_valid_q, out_valid_d;
  out_item_t           out_item_q, out_item_d;

  // position map: index to heap slot
  logic [SlotBits-1:0] pos_mem_q [Capacity];
  logic [SlotBits-1:0] pos_rd_q;
  logic                pos_we;
  logic [IdxBits-1:0]  pos_waddr;
  logic [SlotBits-1:0] pos_wdata;

  // heap memory ports
  logic                heap_we;
  logic [IdxBits-1:0]  heap_waddr;
  heap_entry_t         heap_wdata;
  logic [IdxBits-1:0]  heap_raddr_a, heap_raddr_b;
  heap_entry_t         heap_a, heap_b;

  logic                accept;
  logic [SlotBits:0]   two_p;
  logic [SlotBits:0]   count_ext;
  logic                pick_b;
  heap_entry_t         child;
  logic [SlotBits:0]   child_slot;
  logic                present;

  impq_heap_mem u_heap (
    .clk_i     (clk_i),
    .we_i      (heap_we),
    .waddr_i   (heap_waddr),
    .wdata_i   (heap_wdata),
    .raddr_a_i (heap_raddr_a),
    .raddr_b_i (heap_raddr_b),
    .rdata_a_o (heap_a),
    .rdata_b_o (heap_b)
  );

  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i & in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // child arithmetic for the sink step
  assign two_p      = {p_q, 1'b0};
  assign count_ext  = {1'b0, count_q};
  assign pick_b     = (two_p < count_ext) && (heap_a.key > heap_b.key);
  assign child      = pick_b ? heap_b : heap_a;
  assign child_slot = pick_b ? (two_p + (SlotBits+1)'(1)) : two_p;
  assign present    = valid_q[res_idx_q];

  always_comb begin
    state_d     = state_q;
    act_d       = act_q;
    idx_d       = idx_q;
    key_d       = key_q;
    held_d      = held_q;
    p_d         = p_q;
    count_d     = count_q;
    item_d      = item_q;
    swim_d      = swim_q;
    sink_d      = sink_q;
    status_d    = status_q;
    res_idx_d   = res_idx_q;
    res_key_d   = res_key_q;
    removed_d   = removed_q;
    valid_d     = valid_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    out_item_d  = out_item_q;

    heap_we      = 1'b0;
    heap_waddr   = slot_addr({1'b0, p_q});
    heap_wdata   = item_q;
    heap_raddr_a = '0;
    heap_raddr_b = '0;
    pos_we       = 1'b0;
    pos_waddr    = item_q.idx;
    pos_wdata    = p_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          act_d     = in_item_i.action;
          idx_d     = in_item_i.entry_index;
          key_d     = in_item_i.entry_key;
          held_d    = valid_q[in_item_i.entry_index];
          status_d  = ST_OK;
          res_idx_d = in_item_i.entry_index;
          res_key_d = '0;
          removed_d = 1'b0;
          swim_d    = 1'b0;
          sink_d    = 1'b0;
          state_d   = S_LOOK;
        end
      end
      S_LOOK: begin
        // slot of the named index is back; fetch its entry, or the root
        p_d          = pos_rd_q;
        heap_raddr_a = (act_q == ACT_DELMIN) ? '0 : slot_addr({1'b0, pos_rd_q});
        state_d      = S_KEY;
      end
      S_KEY: begin
        state_d = S_FIN;
        case (act_q) inside
          ACT_INSERT: begin
            if (held_q) begin
              status_d  = ST_PRESENT;
              res_key_d = heap_a.key;
            end else if (count_q == SlotBits'(Capacity)) begin
              status_d = ST_CAPACITY;
            end else begin
              count_d        = count_q + SlotBits'(1);
              p_d            = count_q + SlotBits'(1);
              item_d         = '{idx: idx_q, key: key_q};
              swim_d         = 1'b1;
              res_key_d      = key_q;
              valid_d[idx_q] = 1'b1;
              state_d        = S_SW_RD;
            end
          end
          ACT_CHANGE, ACT_DECREASE, ACT_INCREASE: begin
            if (!held_q) begin
              status_d = ST_ABSENT;
            end else if (((act_q == ACT_DECREASE) && !(key_q < heap_a.key)) ||
                         ((act_q == ACT_INCREASE) && !(key_q > heap_a.key))) begin
              status_d  = ST_DIRECTION;
              res_key_d = heap_a.key;
            end else begin
              item_d    = '{idx: idx_q, key: key_q};
              res_key_d = key_q;
              swim_d    = (act_q != ACT_INCREASE);
              sink_d    = (act_q != ACT_DECREASE);
              state_d   = S_SW_RD;
            end
          end
          ACT_DELETE: begin
            if (!held_q) begin
              status_d = ST_ABSENT;
            end else begin
              res_key_d      = heap_a.key;
              removed_d      = 1'b1;
              valid_d[idx_q] = 1'b0;
              state_d        = S_LAST_RD;
            end
          end
          ACT_DELMIN: begin
            if (count_q == '0) begin
              status_d  = ST_CAPACITY;
              res_idx_d = '0;
            end else begin
              res_idx_d           = heap_a.idx;
              res_key_d           = heap_a.key;
              removed_d           = 1'b1;
              p_d                 = SlotBits'(1);
              valid_d[heap_a.idx] = 1'b0;
              state_d             = S_LAST_RD;
            end
          end
          ACT_LOOKUP: begin
            if (!held_q) begin
              status_d = ST_ABSENT;
            end else begin
              res_key_d = heap_a.key;
            end
          end
          default: begin
            count_d = '0;
            valid_d = '0;
          end
        endcase
      end
      S_LAST_RD: begin
        heap_raddr_a = slot_addr({1'b0, count_q});
        state_d      = S_LAST;
      end
      S_LAST: begin
        // last slot fills the hole, unless the hole is the last slot
        count_d = count_q - SlotBits'(1);
        if (p_q == count_q) begin
          state_d = S_FIN;
        end else begin
          item_d  = heap_a;
          swim_d  = 1'b1;
          sink_d  = 1'b1;
          state_d = S_SW_RD;
        end
      end
      S_SW_RD: begin
        if (swim_q && (p_q > SlotBits'(1))) begin
          heap_raddr_a = slot_addr({2'b00, p_q[SlotBits-1:1]});
          state_d      = S_SW_EV;
        end else begin
          state_d = S_SK_RD;
        end
      end
      S_SW_EV: begin
        if (heap_a.key > item_q.key) begin
          heap_we    = 1'b1;
          heap_wdata = heap_a;
          pos_we     = 1'b1;
          pos_waddr  = heap_a.idx;
          p_d        = {1'b0, p_q[SlotBits-1:1]};
          state_d    = S_SW_RD;
        end else begin
          state_d = S_SK_RD;
        end
      end
      S_SK_RD: begin
        if (sink_q && (two_p <= count_ext)) begin
          heap_raddr_a = slot_addr(two_p);
          heap_raddr_b = two_p[IdxBits-1:0];
          state_d      = S_SK_EV;
        end else begin
          state_d = S_PUT;
        end
      end
      S_SK_EV: begin
        if (item_q.key > child.key) begin
          heap_we    = 1'b1;
          heap_wdata = child;
          pos_we     = 1'b1;
          pos_waddr  = child.idx;
          p_d        = child_slot[SlotBits-1:0];
          state_d    = S_SK_RD;
        end else begin
          state_d = S_PUT;
        end
      end
      S_PUT: begin
        heap_we = 1'b1;
        pos_we  = 1'b1;
        state_d = S_FIN;
      end
      S_FIN: begin
        heap_raddr_a = '0;
        state_d      = S_OUT;
      end
      S_OUT: begin
        // root is back; hold until the output register is free
        if (!out_valid_q || out_ready_i) begin
          out_valid_d             = 1'b1;
          out_item_d.status       = status_q;
          out_item_d.result_index = res_idx_q;
          out_item_d.result_key   = (present || removed_q) ? res_key_q : '0;
          out_item_d.is_present   = present;
          out_item_d.entry_count  = count_q;
          out_item_d.is_empty     = (count_q == '0);
          out_item_d.least_index  = (count_q != '0) ? heap_a.idx : '0;
          out_item_d.least_key    = (count_q != '0) ? heap_a.key : '0;
          state_d                 = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
      swim_q      <= 1'b0;
      sink_q      <= 1'b0;
      removed_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      valid_q     <= valid_d;
      out_valid_q <= out_valid_d;
      swim_q      <= swim_d;
      sink_q      <= sink_d;
      removed_q   <= removed_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    act_q      <= act_d;
    idx_q      <= idx_d;
    key_q      <= key_d;
    held_q     <= held_d;
    p_q        <= p_d;
    item_q     <= item_d;
    status_q   <= status_d;
    res_idx_q  <= res_idx_d;
    res_key_q  <= res_key_d;
    out_item_q <= out_item_d;
  end

  // position memory, read on accept
  always_ff @(posedge clk_i) begin
    if (pos_we) begin
      pos_mem_q[pos_waddr] <= pos_wdata;
    end
    if (accept) begin
      pos_rd_q <= pos_mem_q[in_item_i.entry_index];
    end
  end

  // presence bits agree with the count between items
  `IMPQ_ASSERT_IMPL(a_count_matches_valid, state_q == S_IDLE,
    $countones(valid_q) == int'(count_q), "presence bits disagree with count")
  // final hole lies inside the heap
  `IMPQ_ASSERT_IMPL(a_put_in_heap, state_q == S_PUT,
    (p_q != '0) && (p_q <= count_q), "sift ended outside the heap")
  // a swim step only runs below the root
  `IMPQ_ASSERT_IMPL(a_swim_below_root, state_q == S_SW_EV,
    p_q > SlotBits'(1), "swim step at the root")
  // a free output register takes the result at once
  `IMPQ_ASSERT_NEXT(a_result_loaded, (state_q == S_OUT) && !out_valid_o,
    out_valid_o && (state_q == S_IDLE), "result not loaded")

endmodule

// File: sim/indexed_min_priority_queue_tb.sv
// testbench for the indexed min priority queue: directed table, random traffic, heap predictor
module indexed_min_priority_queue_tb;
  import impq_pkg::*;

  localparam int unsigned StallLimit = 4000;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  in_item_t  in_item_i;
  logic      out_valid_o;
  logic      out_ready_i;
  out_item_t out_item_o;

  indexed_min_priority_queue uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

  // predictor state: heap of indices (1-based), slot of each index, keys, count
  logic [IdxBits-1:0]  heap_idx [Capacity+1];
  logic [SlotBits-1:0] slot_of  [Capacity];
  logic [KeyBits-1:0]  key_of   [Capacity];
  int unsigned         held;

  out_item_t expected_q [$];
  int unsigned fail_count;
  int unsigned items_sent;
  int unsigned items_seen;
  int unsigned idle_cycles;
  int unsigned act_seen [8];

  // directed rows: action, index, key, whether the row holds a typed result, the result
  typedef struct packed {
    action_e   action;
    logic [7:0] idx;
    logic [31:0] key;
    logic      typed;
    out_item_t result;
  } row_t;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [KeyBits-1:0] key_in_slot(int unsigned s);
    return key_of[heap_idx[s]];
  endfunction

  function automatic void swap_slots(int unsigned a, int unsigned b);
    logic [IdxBits-1:0] t;
    t = heap_idx[a];
    heap_idx[a] = heap_idx[b];
    heap_idx[b] = t;
    slot_of[heap_idx[a]] = SlotBits'(a);
    slot_of[heap_idx[b]] = SlotBits'(b);
  endfunction

  function automatic void bubble_up(int unsigned s);
    while (s > 1 && key_in_slot(s / 2) > key_in_slot(s)) begin
      swap_slots(s, s / 2);
      s = s / 2;
    end
  endfunction

  function automatic void push_down(int unsigned s);
    int unsigned c;
    while (2 * s <= held) begin
      c = 2 * s;
      if (c < held && key_in_slot(c) > key_in_slot(c + 1)) c++;
      if (!(key_in_slot(s) > key_in_slot(c))) break;
      swap_slots(s, c);
      s = c;
    end
  endfunction

  function automatic void take_out(int unsigned s);
    logic [IdxBits-1:0] gone;
    gone = heap_idx[s];
    if (s != held) begin
      swap_slots(s, held);
      held--;
      bubble_up(s);
      push_down(s);
    end else begin
      held--;
    end
    slot_of[gone] = '0;
  endfunction

  // applies one action to the predictor and returns the expected result
  function automatic out_item_t heap_apply(in_item_t it);
    out_item_t r;
    logic [IdxBits-1:0] ridx;
    logic [KeyBits-1:0] rkey;
    bit keep_key;
    bit here;
    status_e st;
    st = ST_OK;
    ridx = it.entry_index;
    rkey = '0;
    keep_key = 1'b0;
    here = slot_of[it.entry_index] != 0;
    case (it.action)
      ACT_INSERT: begin
        if (here) st = ST_PRESENT;
        else if (held >= Capacity) st = ST_CAPACITY;
        else begin
          held++;
          heap_idx[held] = it.entry_index;
          slot_of[it.entry_index] = SlotBits'(held);
          key_of[it.entry_index] = it.entry_key;
          bubble_up(held);
        end
      end
      ACT_CHANGE, ACT_DECREASE, ACT_INCREASE: begin
        if (!here) st = ST_ABSENT;
        else if (it.action == ACT_DECREASE && !(it.entry_key < key_of[it.entry_index]))
          st = ST_DIRECTION;
        else if (it.action == ACT_INCREASE && !(it.entry_key > key_of[it.entry_index]))
          st = ST_DIRECTION;
        else begin
          key_of[it.entry_index] = it.entry_key;
          if (it.action != ACT_INCREASE) bubble_up(slot_of[it.entry_index]);
          if (it.action != ACT_DECREASE) push_down(slot_of[it.entry_index]);
        end
      end
      ACT_DELETE: begin
        if (!here) st = ST_ABSENT;
        else begin
          rkey = key_of[it.entry_index];
          keep_key = 1'b1;
          take_out(slot_of[it.entry_index]);
        end
      end
      ACT_DELMIN: begin
        if (held == 0) begin
          st = ST_CAPACITY;
          ridx = '0;
        end else begin
          ridx = heap_idx[1];
          rkey = key_in_slot(1);
          keep_key = 1'b1;
          take_out(1);
        end
      end
      ACT_LOOKUP: if (!here) st = ST_ABSENT;
      default: begin
        held = 0;
        foreach (slot_of[i]) slot_of[i] = '0;
      end
    endcase
    r.status       = st;
    r.result_index = ridx;
    r.is_present   = slot_of[ridx] != 0;
    r.result_key   = keep_key ? rkey : (r.is_present ? key_of[ridx] : '0);
    r.entry_count  = SlotBits'(held);
    r.is_empty     = held == 0;
    r.least_index  = held != 0 ? heap_idx[1] : '0;
    r.least_key    = held != 0 ? key_in_slot(1) : '0;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch on item %0d: %s got %0h, want %0h", items_seen, what, got, want);
    fail_count++;
  endtask

  // sends one item, waiting its random gap first; typed rows are cross-checked
  task automatic send_item(in_item_t it, bit typed, out_item_t typed_res);
    out_item_t want;
    int unsigned gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    want = heap_apply(it);
    if (typed && want != typed_res) begin
      $display("table row disagrees with predictor for action %s", it.action.name());
      fail_count++;
    end
    expected_q.push_back(want);
    act_seen[it.action]++;
    in_item_i  <= it;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
  endtask

  function automatic out_item_t res(status_e st, logic [7:0] ri, logic [31:0] rk, logic p,
                                    int unsigned cnt, logic [7:0] li, logic [31:0] lk);
    out_item_t r;
    r = '{st, ri, rk, p, cnt[8:0], cnt == 0, li, lk};
    return r;
  endfunction

  // random index from a narrow pool most of the time so that hits are common
  function automatic logic [7:0] pick_index(bit narrow);
    return narrow ? 8'($urandom_range(0, 15)) : 8'($urandom_range(0, 255));
  endfunction

  // result side: random stall per item, field by field compare against the oldest entry
  initial begin
    out_item_t want;
    int unsigned stall;
    out_ready_i = 1'b0;
    items_seen  = 0;
    fail_count  = 0;
    @(posedge rst_ni);
    forever begin
      stall = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15);
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      if (expected_q.size() == 0) begin
        $display("result with nothing expected: %p", out_item_o);
        fail_count++;
      end else begin
        want = expected_q.pop_front();
        if (out_item_o.status != want.status)
          report_mismatch("status", 64'(out_item_o.status), 64'(want.status));
        if (out_item_o.result_index != want.result_index)
          report_mismatch("result_index", 64'(out_item_o.result_index),
                          64'(want.result_index));
        if (out_item_o.result_key != want.result_key)
          report_mismatch("result_key", 64'(out_item_o.result_key), 64'(want.result_key));
        if (out_item_o.is_present != want.is_present)
          report_mismatch("is_present", 64'(out_item_o.is_present), 64'(want.is_present));
        if (out_item_o.entry_count != want.entry_count)
          report_mismatch("entry_count", 64'(out_item_o.entry_count),
                          64'(want.entry_count));
        if (out_item_o.is_empty != want.is_empty)
          report_mismatch("is_empty", 64'(out_item_o.is_empty), 64'(want.is_empty));
        if (out_item_o.least_index != want.least_index)
          report_mismatch("least_index", 64'(out_item_o.least_index),
                          64'(want.least_index));
        if (out_item_o.least_key != want.least_key)
          report_mismatch("least_key", 64'(out_item_o.least_key), 64'(want.least_key));
      end
      items_seen++;
    end
  end

  // watchdog: any cycle with no handshake on either side counts toward the limit
  initial begin
    idle_cycles = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= StallLimit) begin
        $display("watchdog: no item moved for %0d cycles", StallLimit);
        $display("indexed_min_priority_queue_tb: errors");
        $finish;
      end
    end
  end

  // stimulus
  initial begin
    row_t rows [$];
    in_item_t it;
    int unsigned burst;
    int unsigned tail;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    in_item_i  = '0;
    items_sent = 0;
    held       = 0;
    foreach (slot_of[i]) slot_of[i] = '0;
    foreach (act_seen[i]) act_seen[i] = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // after reset: empty queue answers
    rows.push_back('{ACT_DELMIN, 8'd0, 32'd0, 1'b1,
                     res(ST_CAPACITY, 8'd0, 32'd0, 1'b0, 0, 8'd0, 32'd0)});
    rows.push_back('{ACT_LOOKUP, 8'd255, 32'd0, 1'b1,
                     res(ST_ABSENT, 8'd255, 32'd0, 1'b0, 0, 8'd0, 32'd0)});
    rows.push_back('{ACT_CHANGE, 8'd3, 32'd9, 1'b1,
                     res(ST_ABSENT, 8'd3, 32'd0, 1'b0, 0, 8'd0, 32'd0)});
    rows.push_back('{ACT_DELETE, 8'd0, 32'd0, 1'b1,
                     res(ST_ABSENT, 8'd0, 32'd0, 1'b0, 0, 8'd0, 32'd0)});
    // extremes of index and key
    rows.push_back('{ACT_INSERT, 8'd255, 32'hFFFF_FFFF, 1'b1,
                     res(ST_OK, 8'd255, 32'hFFFF_FFFF, 1'b1, 1, 8'd255, 32'hFFFF_FFFF)});
    rows.push_back('{ACT_INSERT, 8'd0, 32'd0, 1'b1,
                     res(ST_OK, 8'd0, 32'd0, 1'b1, 2, 8'd0, 32'd0)});
    rows.push_back('{ACT_INSERT, 8'd0, 32'd5, 1'b1,
                     res(ST_PRESENT, 8'd0, 32'd0, 1'b1, 2, 8'd0, 32'd0)});
    // wrong key direction, both ways
    rows.push_back('{ACT_DECREASE, 8'd0, 32'd0, 1'b1,
                     res(ST_DIRECTION, 8'd0, 32'd0, 1'b1, 2, 8'd0, 32'd0)});
    rows.push_back('{ACT_INCREASE, 8'd255, 32'hFFFF_FFFF, 1'b1,
                     res(ST_DIRECTION, 8'd255, 32'hFFFF_FFFF, 1'b1, 2, 8'd0, 32'd0)});
    // valid moves checked by the predictor only
    rows.push_back('{ACT_INSERT, 8'h5A, 32'hA5A5_5A5A, 1'b0, '0});
    rows.push_back('{ACT_INSERT, 8'hA5, 32'h5A5A_A5A5, 1'b0, '0});
    rows.push_back('{ACT_INCREASE, 8'd0, 32'h7FFF_FFFF, 1'b0, '0});
    rows.push_back('{ACT_DECREASE, 8'd255, 32'd1, 1'b0, '0});
    rows.push_back('{ACT_CHANGE, 8'h5A, 32'd0, 1'b0, '0});
    rows.push_back('{ACT_LOOKUP, 8'hA5, 32'd0, 1'b0, '0});
    // delete of a middle heap slot, then the last one, then the minimum
    rows.push_back('{ACT_DELETE, 8'hA5, 32'd0, 1'b0, '0});
    rows.push_back('{ACT_DELETE, 8'd255, 32'd0, 1'b0, '0});
    rows.push_back('{ACT_DELMIN, 8'd0, 32'd0, 1'b0, '0});
    rows.push_back('{ACT_CLEAR, 8'd0, 32'd0, 1'b1,
                     res(ST_OK, 8'd0, 32'd0, 1'b0, 0, 8'd0, 32'd0)});
    foreach (rows[i]) begin
      it = '{rows[i].action, rows[i].idx, rows[i].key};
      send_item(it, rows[i].typed, rows[i].result);
    end

    // random part: fill to capacity once, then mixed bursts of mostly valid operations
    for (int unsigned n = 0; n < 256; n++) begin
      it = '{ACT_INSERT, 8'(n ^ 8'h6B), $urandom()};
      send_item(it, 1'b0, '0);
    end
    it = '{ACT_INSERT, 8'($urandom_range(0, 255)), $urandom()};
    send_item(it, 1'b0, '0);
    for (int unsigned n = 0; n < 12; n++) begin
      it = '{ACT_DELMIN, 8'($urandom()), $urandom()};
      send_item(it, 1'b0, '0);
    end
    it = '{ACT_CLEAR, 8'($urandom()), $urandom()};
    send_item(it, 1'b0, '0);

    while (items_sent < 570) begin
      burst = $urandom_range(0, 9);
      it.entry_index = pick_index($urandom_range(0, 4) != 0);
      // narrow key range sometimes so equal keys turn up
      it.entry_key = $urandom_range(0, 2) == 0 ? 32'($urandom_range(0, 7)) : $urandom();
      if (burst < 4) it.action = ACT_INSERT;
      else if (burst < 9) it.action = action_e'($urandom_range(1, 6));
      else it.action = $urandom_range(0, 20) == 0 ? ACT_CLEAR : ACT_DELMIN;
      send_item(it, 1'b0, '0);
    end
    in_valid_i <= 1'b0;

    // drain, then a quiet tail in case a stray result follows
    tail = 0;
    while (expected_q.size() != 0 && tail < StallLimit) begin
      @(posedge clk_i);
      tail++;
    end
    repeat (60) @(posedge clk_i);
    $display("sent %0d items: %0d inserts, %0d key changes, %0d deletes, %0d delete-min",
             items_sent, act_seen[ACT_INSERT],
             act_seen[ACT_CHANGE] + act_seen[ACT_DECREASE] + act_seen[ACT_INCREASE],
             act_seen[ACT_DELETE], act_seen[ACT_DELMIN]);
    $display("%0d lookups, %0d clears, one pass to full capacity; %0d results checked",
             act_seen[ACT_LOOKUP], act_seen[ACT_CLEAR], items_seen);
    if (fail_count == 0 && expected_q.size() == 0) begin
      $display("indexed_min_priority_queue_tb: clean");
    end else begin
      $display("indexed_min_priority_queue_tb: errors");
    end
    $finish;
  end

endmodule
